/* design/bdq_pkg.sv */
// shared types and codes for the bounded deque core
// no dependencies; used by bdq_cell and bounded_deque_core
package bdq_pkg;

  localparam int unsigned WordW = 32;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_TRAVERSE   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2
  } status_e;

  // one-hot shift command broadcast to every cell
  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
    logic rotate;
  } cell_cmd_t;

endpackage

/* design/bounded_deque_core.sv */
// bounded double-ended queue of signed words built as a chain of shifting cells
// push/pop results are valid the cycle after input; one beat per cycle unless stalled
// traverse of n words blocks input until done, emitting one beat per cycle unless stalled
// single output register: a new input beat is taken in the cycle the waiting result leaves
// reset: async active low, clears cell occupied flags, count and output valid; queue empty
// depends on bdq_pkg and bdq_cell
module bounded_deque_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] value
  input  logic [7:0]  s_axis_tuser,  // [2:0] operation, [7:3] zero pad
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [31:0] data
  output logic [7:0]  m_axis_tuser,  // [1:0] status, [2] data_valid, [7:3] zero pad
  output logic        m_axis_tlast   // last
);

  // count holds 0..DEPTH
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_TRAV
  } state_e;

  state_e                           state_q;
  logic [CW-1:0]                    count_q;
  logic [CW-1:0]                    tidx_q;   // traverse position from the front

  // output register
  logic                             out_vld_q;
  logic signed [bdq_pkg::WordW-1:0] out_data_q;
  bdq_pkg::status_e                 out_status_q;
  logic                             out_dvld_q;
  logic                             out_last_q;

  // cell chain
  logic signed [bdq_pkg::WordW-1:0] cell_word [DEPTH];
  logic signed [bdq_pkg::WordW-1:0] cell_tap  [DEPTH];
  logic [DEPTH-1:0]                 cell_vld;
  logic signed [bdq_pkg::WordW-1:0] rear_word;
  bdq_pkg::cell_cmd_t               cmd;

  logic                             out_free;
  logic                             out_load;
  logic                             in_beat;
  logic                             is_full;
  logic                             is_empty;
  logic                             trav_step;
  logic                             trav_last;
  bdq_pkg::op_e                     op;
  logic signed [bdq_pkg::WordW-1:0] in_value;

  assign op       = bdq_pkg::op_e'(s_axis_tuser[2:0]);
  assign in_value = s_axis_tdata;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign is_full       = (count_q == CW'(DEPTH));
  assign is_empty      = (count_q == '0);
  assign trav_step     = (state_q == S_TRAV) && out_free;
  assign trav_last     = ((tidx_q + CW'(1)) == count_q);

  // a result beat is loaded this cycle
  always_comb begin
    out_load = trav_step;
    if (in_beat) begin
      unique case (op)
        bdq_pkg::OP_PUSH_FRONT,
        bdq_pkg::OP_PUSH_REAR,
        bdq_pkg::OP_POP_FRONT,
        bdq_pkg::OP_POP_REAR:  out_load = 1'b1;
        bdq_pkg::OP_TRAVERSE:  out_load = is_empty;
        default:               out_load = 1'b0;
      endcase
    end
  end

  // the rear cell is the only one with a nonzero tap
  always_comb begin
    rear_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_word = rear_word | cell_tap[i];
    end
  end

  // chain command for this cycle
  always_comb begin
    cmd = '0;
    if (in_beat) begin
      unique case (op)
        bdq_pkg::OP_PUSH_FRONT: cmd.push_front = !is_full;
        bdq_pkg::OP_PUSH_REAR:  cmd.push_rear  = !is_full;
        bdq_pkg::OP_POP_FRONT:  cmd.pop_front  = !is_empty;
        bdq_pkg::OP_POP_REAR:   cmd.pop_rear   = !is_empty;
        default: ;
      endcase
    end
    if (trav_step) begin
      cmd.rotate = 1'b1;
    end
  end

  // cell 0 sees the input value on its left, the last cell sees an empty slot on its right
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [bdq_pkg::WordW-1:0] left_word;
    logic                             left_vld;
    logic signed [bdq_pkg::WordW-1:0] right_word;
    logic                             right_vld;

    if (g == 0) begin : g_first
      assign left_word = in_value;
      assign left_vld  = 1'b1;
    end else begin : g_mid_l
      assign left_word = cell_word[g-1];
      assign left_vld  = cell_vld[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_word = '0;
      assign right_vld  = 1'b0;
    end else begin : g_mid_r
      assign right_word = cell_word[g+1];
      assign right_vld  = cell_vld[g+1];
    end

    bdq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .value_i      (in_value),
      .left_word_i  (left_word),
      .left_vld_i   (left_vld),
      .right_word_i (right_word),
      .right_vld_i  (right_vld),
      .front_word_i (cell_word[0]),
      .word_o       (cell_word[g]),
      .vld_o        (cell_vld[g]),
      .tap_o        (cell_tap[g])
    );
  end

  // control state, count and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      tidx_q       <= '0;
      out_vld_q    <= 1'b0;
      out_data_q   <= '0;
      out_status_q <= bdq_pkg::ST_OK;
      out_dvld_q   <= 1'b0;
      out_last_q   <= 1'b0;
    end else begin
      // a loaded beat stays until the sink takes it
      out_vld_q <= out_load || (out_vld_q && !m_axis_tready);
      unique case (state_q)
        S_IDLE: begin
          if (in_beat) begin
            unique case (op)
              bdq_pkg::OP_PUSH_FRONT,
              bdq_pkg::OP_PUSH_REAR: begin
                out_data_q   <= '0;
                out_dvld_q   <= 1'b0;
                out_last_q   <= 1'b1;
                if (is_full) begin
                  out_status_q <= bdq_pkg::ST_OVER;
                end else begin
                  out_status_q <= bdq_pkg::ST_OK;
                  count_q      <= count_q + CW'(1);
                end
              end
              bdq_pkg::OP_POP_FRONT,
              bdq_pkg::OP_POP_REAR: begin
                out_last_q <= 1'b1;
                if (is_empty) begin
                  out_status_q <= bdq_pkg::ST_UNDER;
                  out_data_q   <= '0;
                  out_dvld_q   <= 1'b0;
                end else begin
                  out_status_q <= bdq_pkg::ST_OK;
                  out_data_q   <= (op == bdq_pkg::OP_POP_FRONT) ? cell_word[0] : rear_word;
                  out_dvld_q   <= 1'b1;
                  count_q      <= count_q - CW'(1);
                end
              end
              bdq_pkg::OP_TRAVERSE: begin
                if (is_empty) begin
                  out_status_q <= bdq_pkg::ST_UNDER;
                  out_data_q   <= '0;
                  out_dvld_q   <= 1'b0;
                  out_last_q   <= 1'b1;
                end else begin
                  state_q <= S_TRAV;
                  tidx_q  <= '0;
                end
              end
              default: ;  // unused opcodes produce no beat
            endcase
          end
        end
        S_TRAV: begin
          if (trav_step) begin
            out_status_q <= bdq_pkg::ST_OK;
            out_data_q   <= cell_word[0];
            out_dvld_q   <= 1'b1;
            out_last_q   <= trav_last;
            tidx_q       <= tidx_q + CW'(1);
            if (trav_last) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = {5'b0, out_dvld_q, out_status_q};
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  // occupancy never exceeds the cell count
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("deque count above depth");

  // occupied flags in the chain agree with the count
  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_vld) == int'(count_q))
    else $error("cell occupancy disagrees with count");

  // a traverse only runs over a nonempty queue and within it
  a_trav_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TRAV |-> (count_q != '0) && (tidx_q < count_q))
    else $error("traverse position out of range");

  // no new input while a traverse is emitting
  a_trav_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TRAV |-> !s_axis_tready)
    else $error("input accepted during traverse");

  // the count is only touched by an input beat
  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_beat |=> $stable(count_q))
    else $error("count changed without input beat");
`endif

endmodule

/* design/bdq_cell.sv */
// one storage cell of the deque chain: a word and its occupied flag
// depends on bdq_pkg for the command struct and word width
module bdq_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bdq_pkg::cell_cmd_t              cmd_i,
  input  logic signed [bdq_pkg::WordW-1:0] value_i,
  input  logic signed [bdq_pkg::WordW-1:0] left_word_i,
  input  logic                            left_vld_i,
  input  logic signed [bdq_pkg::WordW-1:0] right_word_i,
  input  logic                            right_vld_i,
  input  logic signed [bdq_pkg::WordW-1:0] front_word_i,
  output logic signed [bdq_pkg::WordW-1:0] word_o,
  output logic                            vld_o,
  output logic signed [bdq_pkg::WordW-1:0] tap_o
);

  logic signed [bdq_pkg::WordW-1:0] word_q, word_d;
  logic                             vld_q, vld_d;

  always_comb begin
    word_d = word_q;
    vld_d  = vld_q;
    priority if (cmd_i.push_front) begin
      word_d = left_word_i;
      vld_d  = left_vld_i;
    end else if (cmd_i.push_rear) begin
      // first free cell after the occupied run
      if (!vld_q && left_vld_i) begin
        word_d = value_i;
        vld_d  = 1'b1;
      end
    end else if (cmd_i.pop_front) begin
      word_d = right_word_i;
      vld_d  = right_vld_i;
    end else if (cmd_i.pop_rear) begin
      if (vld_q && !right_vld_i) begin
        vld_d = 1'b0;
      end
    end else if (cmd_i.rotate) begin
      // front word wraps around into the rear cell
      if (vld_q) begin
        word_d = right_vld_i ? right_word_i : front_word_i;
      end
    end else begin
      // no command: cell holds
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;
  assign vld_o  = vld_q;
  assign tap_o  = (vld_q && !right_vld_i) ? word_q : '0;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// self-checking bench for bounded_deque_core: directed and random deque commands
// against a shadow deque, with random stalls on both streams; depends on bdq_pkg
module tb_top;

  localparam int unsigned Depth       = 16;
  localparam int          RandomOps   = 280;
  localparam int          IdleLimit   = 2000;
  localparam int          TailCycles  = 20;
  localparam logic [2:0]  OpFirstUnused = 3'd5;
  localparam logic [2:0]  OpLastCode    = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] value;
    bit          wait_drain;  // hold this beat back until every result is in
  } deque_cmd_t;

  typedef struct {
    bdq_pkg::status_e status;
    logic [31:0]      data;
    logic             data_valid;
    logic             last;
  } deque_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] value
  logic [7:0]  s_axis_tuser;   // [2:0] operation, [7:3] zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [31:0] data
  logic [7:0]  m_axis_tuser;   // [1:0] status, [2] data_valid, [7:3] zero pad
  logic        m_axis_tlast;

  deque_cmd_t    cmd_queue[$];
  deque_result_t awaited_results[$];

  // shadow copy of the deque contents
  logic [31:0] shadow_words[Depth];
  int          shadow_head;
  int          shadow_count;

  int total_cmds;
  int accepted_cmds;
  int error_count = 0;
  int idle_cycles;
  int send_idle_pct;
  int recv_idle_pct;

  bounded_deque_core #(.DEPTH(Depth)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // stall mix by thirds of the run: receiver-heavy, sender-heavy, then none
  always_comb begin
    if (accepted_cmds < total_cmds / 3) begin
      send_idle_pct = 33;
      recv_idle_pct = 47;
    end else if (accepted_cmds < (2 * total_cmds) / 3) begin
      send_idle_pct = 47;
      recv_idle_pct = 33;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  task automatic add_result(bdq_pkg::status_e status, logic [31:0] data, logic data_valid,
                            logic last);
    awaited_results.push_back('{status, data, data_valid, last});
  endtask

  // apply one command to the shadow deque and queue up the beats it must produce
  task automatic run_shadow_deque(logic [2:0] op, logic [31:0] value);
    int slot;
    case (op)
      bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_REAR: begin
        if (shadow_count == Depth) begin
          add_result(bdq_pkg::ST_OVER, '0, 1'b0, 1'b1);
        end else begin
          if (op == bdq_pkg::OP_PUSH_FRONT) begin
            shadow_head = (shadow_head + Depth - 1) % Depth;
            slot = shadow_head;
          end else begin
            slot = (shadow_head + shadow_count) % Depth;
          end
          shadow_words[slot] = value;
          shadow_count++;
          add_result(bdq_pkg::ST_OK, '0, 1'b0, 1'b1);
        end
      end
      bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_REAR: begin
        if (shadow_count == 0) begin
          add_result(bdq_pkg::ST_UNDER, '0, 1'b0, 1'b1);
        end else begin
          if (op == bdq_pkg::OP_POP_FRONT) begin
            slot = shadow_head;
            shadow_head = (shadow_head + 1) % Depth;
          end else begin
            slot = (shadow_head + shadow_count - 1) % Depth;
          end
          shadow_count--;
          add_result(bdq_pkg::ST_OK, shadow_words[slot], 1'b1, 1'b1);
        end
      end
      bdq_pkg::OP_TRAVERSE: begin
        if (shadow_count == 0) begin
          add_result(bdq_pkg::ST_UNDER, '0, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            add_result(bdq_pkg::ST_OK, shadow_words[(shadow_head + i) % Depth], 1'b1,
                       i == shadow_count - 1);
          end
        end
      end
      default: ;  // unused codes leave the deque alone and produce nothing
    endcase
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // driver: offers the next command unless stalled, predicts on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      accepted_cmds <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        run_shadow_deque(s_axis_tuser[2:0], s_axis_tdata);
        accepted_cmds <= accepted_cmds + 1;
      end
      // a beat still waiting for tready stays on the bus untouched
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
            !(cmd_queue[0].wait_drain && awaited_results.size() != 0)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= cmd_queue[0].value;
          s_axis_tuser  <= {5'd0, cmd_queue[0].op};
          void'(cmd_queue.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result beat against the oldest awaited one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected beat, data", m_axis_tdata, '0);
        end else begin
          if (m_axis_tuser[1:0] != awaited_results[0].status)
            report_mismatch("status", 32'(m_axis_tuser[1:0]),
                            32'(awaited_results[0].status));
          if (m_axis_tdata != awaited_results[0].data)
            report_mismatch("data", m_axis_tdata, awaited_results[0].data);
          if (m_axis_tuser[2] != awaited_results[0].data_valid)
            report_mismatch("data_valid", 32'(m_axis_tuser[2]),
                            32'(awaited_results[0].data_valid));
          if (m_axis_tlast != awaited_results[0].last)
            report_mismatch("last", 32'(m_axis_tlast), 32'(awaited_results[0].last));
          void'(awaited_results.pop_front());
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles with no beat moving on either stream
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int          counted;
    int          burst_len;
    int          burst_idx;
    int          pick;
    bit          filling;
    logic [2:0]  op;
    logic [31:0] value;

    rst_ni        = 1'b0;
    shadow_head   = 0;
    shadow_count  = 0;
    foreach (shadow_words[i]) shadow_words[i] = '0;

    // directed: underflow on empty, unused codes, fill with extremes, overflow, full walk
    cmd_queue.push_back('{bdq_pkg::OP_POP_FRONT, 32'h0, 1'b0});
    cmd_queue.push_back('{bdq_pkg::OP_POP_REAR, 32'h0, 1'b0});
    cmd_queue.push_back('{bdq_pkg::OP_TRAVERSE, 32'h0, 1'b0});
    for (int c = OpFirstUnused; c <= OpLastCode; c++)
      cmd_queue.push_back('{c[2:0], 32'hFFFF_FFFF, 1'b0});
    for (int i = 0; i < Depth; i++) begin
      case (i % 4)
        0: value = 32'h8000_0000;
        1: value = 32'h7FFF_FFFF;
        2: value = 32'hFFFF_FFFF;
        default: value = i;
      endcase
      cmd_queue.push_back('{(i % 2) ? bdq_pkg::OP_PUSH_REAR : bdq_pkg::OP_PUSH_FRONT,
                            value, 1'b0});
    end
    cmd_queue.push_back('{bdq_pkg::OP_PUSH_FRONT, 32'h1234_5678, 1'b0});
    cmd_queue.push_back('{bdq_pkg::OP_PUSH_REAR, 32'h8765_4321, 1'b0});
    cmd_queue.push_back('{bdq_pkg::OP_TRAVERSE, 32'h0, 1'b0});

    // random: bursts that lean toward filling or draining so both ends get hit
    counted   = 0;
    burst_idx = 0;
    while (counted < RandomOps) begin
      filling   = 1'($urandom_range(0, 1));
      burst_len = $urandom_range(8, 30);
      for (int k = 0; k < burst_len; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 4)
          op = 3'($urandom_range(OpFirstUnused, OpLastCode));
        else if (pick < 14)
          op = bdq_pkg::OP_TRAVERSE;
        else if ((pick < 80) == filling)
          op = $urandom_range(0, 1) ? bdq_pkg::OP_PUSH_FRONT : bdq_pkg::OP_PUSH_REAR;
        else
          op = $urandom_range(0, 1) ? bdq_pkg::OP_POP_FRONT : bdq_pkg::OP_POP_REAR;
        case ($urandom_range(0, 7))
          0: value = 32'h8000_0000;
          1: value = 32'h7FFF_FFFF;
          default: value = $urandom;
        endcase
        // every fifth burst opens with a full drain of the result stream
        cmd_queue.push_back('{op, value, (k == 0) && (burst_idx % 5 == 0)});
        if (op < OpFirstUnused) counted++;
      end
      burst_idx++;
    end
    total_cmds = cmd_queue.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_queue.size() != 0 || s_axis_tvalid || awaited_results.size() != 0)
      @(posedge clk_i);
    // let any stray beat show up before closing
    repeat (TailCycles) @(posedge clk_i);

    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
